>>> rtl/core/fde_pkg.sv
// Shared constants, codes and types of the frame difference event accumulator.
package fde_pkg;

  // Largest frame the stores hold.
  localparam int MAX_WIDTH    = 512;
  localparam int MAX_HEIGHT   = 512;
  localparam int FRAME_PIXELS = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W       = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  // Widths of the clamped frame size and of the pixel count.
  localparam int WIDTH_W  = $clog2(MAX_WIDTH + 1);
  localparam int HEIGHT_W = $clog2(MAX_HEIGHT + 1);
  localparam int TOTAL_W  = WIDTH_W + HEIGHT_W;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;
  localparam int THRESHOLD_W = 8;
  localparam int DIM_REG_W   = 10;

  localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 8'd10;
  localparam logic [DIM_REG_W-1:0]   WIDTH_RESET     = 10'd512;
  localparam logic [DIM_REG_W-1:0]   HEIGHT_RESET    = 10'd512;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD    = 2'd0,
    REG_FRAME_WIDTH  = 2'd1,
    REG_FRAME_HEIGHT = 2'd2
  } cfg_reg_e;

  // Input beat.
  typedef struct packed {
    logic [7:0] in_blue;
    logic [7:0] in_green;
    logic [7:0] in_red;
  } pix_in_t;

  // Output beat.
  typedef struct packed {
    logic [7:0] acc_blue;
    logic [7:0] acc_green;
    logic [7:0] acc_red;
    logic       end_of_frame;
  } pix_out_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  // One store word: previous pixel and accumulator of one position.
  typedef struct packed {
    rgb_t prev;
    rgb_t acc;
  } mem_word_t;

  localparam int MEM_W = $bits(mem_word_t);

  // Raster position of the pixel that enters the read stage.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic              last;
  } pos_info_t;

  // Store clearing sweep after reset.
  typedef struct packed {
    logic              active;
    logic [ADDR_W-1:0] addr;
  } clear_t;

  // Read-after-write bypass selects for the update stage.
  typedef struct packed {
    logic hit_new;
    logic hit_old;
  } fwd_t;

endpackage

>>> rtl/core/fde_ram.sv
// Generic single-write, single-read memory with registered read data.
module fde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

endmodule

>>> rtl/core/fde_ctrl.sv
// Configuration registers, frame size, raster position and store clearing sweep.
module fde_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [fde_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fde_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               step,
  output fde_pkg::pos_info_t                 info,
  output logic [fde_pkg::THRESHOLD_W-1:0]    threshold,
  output fde_pkg::clear_t                    clr
);

  logic [fde_pkg::DIM_REG_W-1:0] frame_width;
  logic [fde_pkg::DIM_REG_W-1:0] frame_height;
  logic [fde_pkg::WIDTH_W-1:0]   width_used;
  logic [fde_pkg::HEIGHT_W-1:0]  height_used;
  logic [fde_pkg::TOTAL_W-1:0]   total;
  logic [fde_pkg::ADDR_W-1:0]    position;
  logic [fde_pkg::ADDR_W-1:0]    position_next;
  logic [fde_pkg::ADDR_W-1:0]    pos_eff;
  logic                          pos_last;

  // Register writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= fde_pkg::THRESHOLD_RESET;
      frame_width  <= fde_pkg::WIDTH_RESET;
      frame_height <= fde_pkg::HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        fde_pkg::REG_THRESHOLD: begin
          threshold <= cfg_data[fde_pkg::THRESHOLD_W-1:0];
        end
        fde_pkg::REG_FRAME_WIDTH: begin
          frame_width <= cfg_data[fde_pkg::DIM_REG_W-1:0];
        end
        fde_pkg::REG_FRAME_HEIGHT: begin
          frame_height <= cfg_data[fde_pkg::DIM_REG_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // Clamp the frame size to one pixel up to the store size.
  always_comb begin
    if (frame_width == '0) begin
      width_used = fde_pkg::WIDTH_W'(1);
    end else if (int'(frame_width) > fde_pkg::MAX_WIDTH) begin
      width_used = fde_pkg::WIDTH_W'(fde_pkg::MAX_WIDTH);
    end else begin
      width_used = fde_pkg::WIDTH_W'(frame_width);
    end
    if (frame_height == '0) begin
      height_used = fde_pkg::HEIGHT_W'(1);
    end else if (int'(frame_height) > fde_pkg::MAX_HEIGHT) begin
      height_used = fde_pkg::HEIGHT_W'(fde_pkg::MAX_HEIGHT);
    end else begin
      height_used = fde_pkg::HEIGHT_W'(frame_height);
    end
  end

  // Pixel count of the frame, refreshed every cycle.
  always_ff @(posedge clk) begin
    total <= fde_pkg::TOTAL_W'(width_used) * fde_pkg::TOTAL_W'(height_used);
  end

  // A position beyond a shrunken frame starts a new frame.
  always_comb begin
    pos_eff       = (fde_pkg::TOTAL_W'(position) < total) ? position : '0;
    pos_last      = (fde_pkg::TOTAL_W'(pos_eff) == (total - fde_pkg::TOTAL_W'(1)));
    position_next = pos_last ? '0 : (pos_eff + fde_pkg::ADDR_W'(1));
    info.addr     = pos_eff;
    info.last     = pos_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (step) begin
      position <= position_next;
    end
  end

  // Zero the store, previous pixels and accumulators alike, once after reset, one word per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr.active <= 1'b1;
      clr.addr   <= '0;
    end else if (clr.active) begin
      clr.addr <= clr.addr + fde_pkg::ADDR_W'(1);
      if (clr.addr == fde_pkg::ADDR_W'(fde_pkg::FRAME_PIXELS - 1)) begin
        clr.active <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  // The last pixel of a frame sends the position back to the start.
  a_wrap_to_zero: assert property (@(posedge clk) disable iff (rst)
    (step && info.last) |=> (position == '0))
    else $error("position did not wrap after the last pixel of a frame");

  // The store address always lies inside the configured frame.
  a_addr_in_frame: assert property (@(posedge clk) disable iff (rst)
    (fde_pkg::TOTAL_W'(info.addr) < total))
    else $error("store address outside the configured frame");
`endif

endmodule

>>> rtl/core/fde_update.sv
// Bypass select and per-channel thresholded, saturating accumulator update.
module fde_update (
  input  fde_pkg::rgb_t                      pix,
  input  fde_pkg::mem_word_t                 mem_word,
  input  fde_pkg::mem_word_t                 word_new,
  input  fde_pkg::mem_word_t                 word_old,
  input  fde_pkg::fwd_t                      fwd,
  input  logic [fde_pkg::THRESHOLD_W-1:0]    threshold,
  output fde_pkg::rgb_t                      acc
);

  fde_pkg::mem_word_t base;

  // One channel: drop small differences, add, and saturate to 0..255.
  function automatic logic [7:0] chan_update(input logic [7:0] now,
                                             input logic [7:0] prev,
                                             input logic [7:0] acc_old,
                                             input logic [7:0] thr);
    logic [7:0]        mag;
    logic signed [9:0] sum;
    logic [7:0]        res;
    mag = (now >= prev) ? (now - prev) : (prev - now);
    if (mag < thr) begin
      sum = $signed({2'b00, acc_old});
    end else begin
      sum = $signed({2'b00, acc_old}) + $signed({2'b00, now}) - $signed({2'b00, prev});
    end
    if (sum[9]) begin
      res = 8'd0;
    end else if (sum[8]) begin
      res = 8'd255;
    end else begin
      res = sum[7:0];
    end
    return res;
  endfunction

  // The newest in-flight write of this position wins over the store.
  always_comb begin
    priority if (fwd.hit_new) begin
      base = word_new;
    end else if (fwd.hit_old) begin
      base = word_old;
    end else begin
      base = mem_word;
    end
  end

  always_comb begin
    acc.blue  = chan_update(pix.blue,  base.prev.blue,  base.acc.blue,  threshold);
    acc.green = chan_update(pix.green, base.prev.green, base.acc.green, threshold);
    acc.red   = chan_update(pix.red,   base.prev.red,   base.acc.red,   threshold);
  end

endmodule

>>> rtl/core/frame_diff_event_accumulator.sv
// Top level: pixel pipeline around the previous-frame and accumulator store.
//
//  channel   direction  handshake             payload
//  in        to block   in_valid / in_stall    in_data   (blue, green, red)
//  out       from block out_valid / out_stall  out_data  (accumulators, end_of_frame)
//  cfg       to block   cfg_write              cfg_index, cfg_data
//
// One pixel per cycle is taken while in_stall is low; a result passes the input
// register and store read, the store data, then the update into the output
// register.
// After reset all FRAME_PIXELS (262144) store words are swept to zero,
// with in_stall high; configuration writes are taken during the sweep.
// A stalled output holds the whole pipeline in place; in_stall then rises.
// Back-to-back pixels of the same position are served by two bypass words.
module frame_diff_event_accumulator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  fde_pkg::pix_in_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output fde_pkg::pix_out_t                  out_data,
  input  logic                               cfg_write,
  input  logic [fde_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [fde_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic                              advance;
  fde_pkg::pos_info_t                info;
  fde_pkg::clear_t                   clr;
  logic [fde_pkg::THRESHOLD_W-1:0]   threshold;

  logic                              s1_valid;
  fde_pkg::rgb_t                     s1_pix;
  logic                              s2_valid;
  fde_pkg::rgb_t                     s2_pix;
  logic [fde_pkg::ADDR_W-1:0]        s2_addr;
  logic                              s2_last;
  logic                              s3_valid;
  fde_pkg::rgb_t                     s3_pix;
  logic [fde_pkg::ADDR_W-1:0]        s3_addr;
  logic                              s3_last;
  fde_pkg::mem_word_t                s3_mem;
  fde_pkg::fwd_t                     s3_fwd;
  fde_pkg::rgb_t                     s3_acc;
  fde_pkg::mem_word_t                s3_word;

  logic                              h1_valid;
  logic [fde_pkg::ADDR_W-1:0]        h1_addr;
  fde_pkg::mem_word_t                h1_word;
  fde_pkg::mem_word_t                h2_word;

  logic                              ram_wr_en;
  logic [fde_pkg::ADDR_W-1:0]        ram_wr_addr;
  logic [fde_pkg::MEM_W-1:0]         ram_wr_data;
  logic                              ram_rd_en;
  logic [fde_pkg::MEM_W-1:0]         ram_rd_data;

  // The pipeline moves as a whole whenever the output register can take a beat.
  assign advance  = !out_valid || !out_stall;
  assign in_stall = clr.active || !advance;

  fde_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .step      (advance && s1_valid),
    .info      (info),
    .threshold (threshold),
    .clr       (clr)
  );

  // Store port: sweep writes during clearing, otherwise the update stage writes back.
  assign ram_rd_en   = advance && s1_valid;
  assign ram_wr_en   = clr.active || (advance && s3_valid);
  assign ram_wr_addr = clr.active ? clr.addr : s3_addr;
  assign ram_wr_data = clr.active ? '0 : fde_pkg::MEM_W'(s3_word);

  fde_ram #(
    .WIDTH (fde_pkg::MEM_W),
    .DEPTH (fde_pkg::FRAME_PIXELS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (info.addr),
    .rd_data (ram_rd_data)
  );

  fde_update u_update (
    .pix       (s3_pix),
    .mem_word  (s3_mem),
    .word_new  (h1_word),
    .word_old  (h2_word),
    .fwd       (s3_fwd),
    .threshold (threshold),
    .acc       (s3_acc)
  );

  assign s3_word.prev = s3_pix;
  assign s3_word.acc  = s3_acc;

  // Pipeline valid bits and the output beat valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
      h1_valid  <= 1'b0;
    end else if (advance) begin
      s1_valid  <= in_valid && !clr.active;
      s2_valid  <= s1_valid;
      s3_valid  <= s2_valid;
      out_valid <= s3_valid;
      h1_valid  <= s3_valid;
    end
  end

  // Pipeline payload; the last two write-backs are kept for the bypass.
  always_ff @(posedge clk) begin
    if (advance) begin
      s1_pix.blue  <= in_data.in_blue;
      s1_pix.green <= in_data.in_green;
      s1_pix.red   <= in_data.in_red;

      s2_pix  <= s1_pix;
      s2_addr <= info.addr;
      s2_last <= info.last;

      s3_pix         <= s2_pix;
      s3_addr        <= s2_addr;
      s3_last        <= s2_last;
      s3_mem         <= fde_pkg::mem_word_t'(ram_rd_data);
      s3_fwd.hit_new <= s3_valid && (s3_addr == s2_addr);
      s3_fwd.hit_old <= h1_valid && (h1_addr == s2_addr);

      out_data.acc_blue     <= s3_acc.blue;
      out_data.acc_green    <= s3_acc.green;
      out_data.acc_red      <= s3_acc.red;
      out_data.end_of_frame <= s3_last;

      h1_addr <= s3_addr;
      h1_word <= s3_word;
      h2_word <= h1_word;
    end
  end

`ifndef ASSERT_OFF
  // No pixel is in flight while the store is being cleared.
  a_empty_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clr.active |-> !(s1_valid || s2_valid || s3_valid || out_valid))
    else $error("pixel in flight during the clearing sweep");

  // Read data must hold while the pipeline is held, or the bypass is wrong.
  a_read_data_held: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(ram_rd_data))
    else $error("store read data changed while the pipeline was held");

  // A write-back and the sweep never compete for the store port.
  a_no_writeback_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (advance && s3_valid) |-> !clr.active)
    else $error("pixel write-back during the clearing sweep");
`endif

endmodule

>>> bench/tb.sv
// Self-checking bench for the frame difference event accumulator.
`timescale 1ns / 1ps

module tb;
  import fde_pkg::*;

  // Cycles from an accepted pixel to its result, plus a small margin.
  localparam int PIPE_LATENCY = 3;
  localparam int SETTLE_CYCLES = PIPE_LATENCY + 4;
  // The store sweep after reset is the longest quiet stretch of a good run.
  localparam int QUIET_LIMIT = 3 * FRAME_PIXELS;
  // Index past the register list; writes to it must change nothing.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

  logic                   clk;
  logic                   rst;
  logic                   in_valid;
  logic                   in_stall;
  pix_in_t                in_data;
  logic                   out_valid;
  logic                   out_stall;
  pix_out_t               out_data;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  // Shadow copy of the stores, the raster position and the registers.
  rgb_t                   prior_pixels [FRAME_PIXELS];
  rgb_t                   event_sums [FRAME_PIXELS];
  int                     raster_pos;
  logic [THRESHOLD_W-1:0] cur_threshold;
  logic [DIM_REG_W-1:0]   cur_width;
  logic [DIM_REG_W-1:0]   cur_height;

  // Accumulator beats still owed by the block, oldest first.
  pix_out_t pending_sums [$];
  pix_out_t want;
  int       mismatches;
  int       quiet_cycles;
  int       send_idle_pct;
  int       stall_idle_pct;

  frame_diff_event_accumulator dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A zero size register acts as one; larger values stop at the store size.
  function automatic int clamp_dim(input logic [DIM_REG_W-1:0] v, input int limit);
    if (v == '0) return 1;
    return (int'(v) > limit) ? limit : int'(v);
  endfunction

  function automatic int frame_total();
    return clamp_dim(cur_width, MAX_WIDTH) * clamp_dim(cur_height, MAX_HEIGHT);
  endfunction

  // A position left beyond a shrunken frame restarts the frame.
  function automatic int next_position();
    return (raster_pos < frame_total()) ? raster_pos : 0;
  endfunction

  // Thresholded difference added to a sum that saturates at 0 and 255.
  function automatic logic [7:0] accumulate_channel(input logic [7:0] now,
                                                    input logic [7:0] old,
                                                    input logic [7:0] sum);
    int delta;
    int total;
    delta = int'(now) - int'(old);
    if ((delta < 0 ? -delta : delta) < int'(cur_threshold)) delta = 0;
    total = int'(sum) + delta;
    if (total > 255) total = 255;
    else if (total < 0) total = 0;
    return total[7:0];
  endfunction

  // Updates the shadow stores for one pixel and returns the expected beat.
  function automatic pix_out_t advance_accumulators(input pix_in_t px);
    int       pos;
    rgb_t     old_px;
    rgb_t     old_sum;
    pix_out_t res;
    pos = next_position();
    old_px = prior_pixels[pos];
    old_sum = event_sums[pos];
    res.acc_blue = accumulate_channel(px.in_blue, old_px.blue, old_sum.blue);
    res.acc_green = accumulate_channel(px.in_green, old_px.green, old_sum.green);
    res.acc_red = accumulate_channel(px.in_red, old_px.red, old_sum.red);
    res.end_of_frame = (pos == frame_total() - 1);
    prior_pixels[pos].blue = px.in_blue;
    prior_pixels[pos].green = px.in_green;
    prior_pixels[pos].red = px.in_red;
    event_sums[pos].blue = res.acc_blue;
    event_sums[pos].green = res.acc_green;
    event_sums[pos].red = res.acc_red;
    raster_pos = res.end_of_frame ? 0 : pos + 1;
    return res;
  endfunction

  function automatic pix_in_t rgb_in(input logic [7:0] b, input logic [7:0] g,
                                     input logic [7:0] r);
    pix_in_t px;
    px.in_blue = b;
    px.in_green = g;
    px.in_red = r;
    return px;
  endfunction

  // Mostly small moves around the threshold, with some jumps and noise.
  function automatic logic [7:0] nudge(input logic [7:0] base);
    int v;
    case ($urandom_range(9))
      0, 1: v = $urandom_range(255);
      2: v = 0;
      3: v = 255;
      default: begin
        v = int'(base) + $urandom_range(2 * int'(cur_threshold) + 4)
            - (int'(cur_threshold) + 2);
      end
    endcase
    if (v > 255) v = 255;
    else if (v < 0) v = 0;
    return v[7:0];
  endfunction

  // Next pixel of the scene, built from what the block last saw there.
  function automatic pix_in_t scene_pixel();
    rgb_t base;
    base = prior_pixels[next_position()];
    return rgb_in(nudge(base.blue), nudge(base.green), nudge(base.red));
  endfunction

  // Sends one pixel beat after an optional idle gap.
  task automatic send_pixel(input pix_in_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_sums.push_back(advance_accumulators(px));
  endtask

  // Lets every owed result drain and the pipeline go quiet.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    settle_block();
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_THRESHOLD: cur_threshold = value[THRESHOLD_W-1:0];
      REG_FRAME_WIDTH: cur_width = value;
      REG_FRAME_HEIGHT: cur_height = value;
      default: ;
    endcase
  endtask

  // The first pixels after reset are compared against black, at the reset settings.
  task automatic test_black_start();
    send_pixel(rgb_in(8'd0, 8'd0, 8'd0));
    send_pixel(rgb_in(8'd255, 8'd255, 8'd255));
    send_pixel(rgb_in(8'd9, 8'd10, 8'd11));
    send_pixel(rgb_in(8'd255, 8'd0, 8'd128));
  endtask

  // No suppression at all; the size shrinks below the current position.
  task automatic test_zero_threshold();
    write_register(REG_THRESHOLD, 10'd0);
    write_register(REG_FRAME_WIDTH, 10'd2);
    write_register(REG_FRAME_HEIGHT, 10'd1);
    send_pixel(rgb_in(8'd1, 8'd0, 8'd255));
    send_pixel(rgb_in(8'd0, 8'd255, 8'd0));
    send_pixel(rgb_in(8'd0, 8'd1, 8'd0));
    send_pixel(rgb_in(8'd255, 8'd255, 8'd255));
  endtask

  // Threshold at its top and in the middle, written with upper data bits set.
  task automatic test_threshold_edges();
    write_register(REG_THRESHOLD, 10'h3FF);
    send_pixel(rgb_in(8'd255, 8'd0, 8'd254));
    send_pixel(rgb_in(8'd0, 8'd255, 8'd1));
    write_register(REG_THRESHOLD, 10'h180);
    send_pixel(rgb_in(8'd128, 8'd127, 8'd0));
    send_pixel(rgb_in(8'd128, 8'd0, 8'd129));
  endtask

  // Zero and oversized frame sizes, and a write past the register list.
  task automatic test_size_clamp();
    write_register(REG_THRESHOLD, 10'd10);
    write_register(REG_FRAME_WIDTH, 10'd0);
    write_register(REG_FRAME_HEIGHT, 10'd0);
    repeat (3) send_pixel(rgb_in(8'd200, 8'd30, 8'd90));
    write_register(REG_FRAME_WIDTH, 10'h3FF);
    write_register(REG_FRAME_HEIGHT, 10'd1);
    send_pixel(rgb_in(8'd17, 8'd240, 8'd5));
    send_pixel(rgb_in(8'd0, 8'd255, 8'd64));
    write_register(REG_FRAME_WIDTH, 10'd1);
    write_register(REG_FRAME_HEIGHT, 10'h3FF);
    send_pixel(rgb_in(8'd99, 8'd100, 8'd101));
    write_register(REG_SPARE, 10'h3FF);
    write_register(REG_FRAME_WIDTH, 10'd3);
    write_register(REG_FRAME_HEIGHT, 10'd1);
    repeat (3) send_pixel(scene_pixel());
  endtask

  // Picks new settings, often changing the size in the middle of a frame.
  task automatic shuffle_settings();
    logic [7:0] thr;
    case ($urandom_range(4))
      0: thr = 8'd0;
      1: thr = 8'd255;
      2: thr = 8'($urandom_range(255));
      default: thr = 8'($urandom_range(40));
    endcase
    if ($urandom_range(1) == 0) write_register(REG_THRESHOLD, {2'($urandom_range(3)), thr});
    if ($urandom_range(3) != 0) write_register(REG_FRAME_WIDTH, 10'($urandom_range(6)));
    if ($urandom_range(3) != 0) write_register(REG_FRAME_HEIGHT, 10'($urandom_range(6)));
    if ($urandom_range(7) == 0) write_register(REG_SPARE, 10'($urandom_range(1023)));
  endtask

  // Whole frames of a slowly changing scene, with some cut short.
  task automatic run_random_phase(input int item_goal, input int send_pct,
                                  input int stall_pct);
    int sent;
    int span;
    sent = 0;
    send_idle_pct = send_pct;
    stall_idle_pct = stall_pct;
    while (sent < item_goal) begin
      shuffle_settings();
      span = frame_total() * $urandom_range(3, 1);
      if ($urandom_range(3) == 0) span = $urandom_range(2 * frame_total(), 1);
      repeat (span) send_pixel(scene_pixel());
      sent += span;
    end
  endtask

  // A full line and more at the widest size, so the flag lands on the last column.
  task automatic test_widest_line();
    send_idle_pct = 36;
    stall_idle_pct = 36;
    write_register(REG_THRESHOLD, 10'($urandom_range(30)));
    write_register(REG_FRAME_WIDTH, 10'd512);
    write_register(REG_FRAME_HEIGHT, 10'd1);
    repeat (MAX_WIDTH + 2) send_pixel(scene_pixel());
  endtask

  // Compares each accepted result beat with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_sums.size() == 0) begin
        $error("result beat with nothing expected: %h", out_data);
        mismatches++;
      end else begin
        want = pending_sums.pop_front();
        if (out_data.acc_blue !== want.acc_blue) begin
          $error("acc_blue: expected %0d, got %0d", want.acc_blue, out_data.acc_blue);
          mismatches++;
        end
        if (out_data.acc_green !== want.acc_green) begin
          $error("acc_green: expected %0d, got %0d", want.acc_green, out_data.acc_green);
          mismatches++;
        end
        if (out_data.acc_red !== want.acc_red) begin
          $error("acc_red: expected %0d, got %0d", want.acc_red, out_data.acc_red);
          mismatches++;
        end
        if (out_data.end_of_frame !== want.end_of_frame) begin
          $error("end_of_frame: expected %0d, got %0d", want.end_of_frame,
                 out_data.end_of_frame);
          mismatches++;
        end
      end
    end
    out_stall <= ($urandom_range(99) < stall_idle_pct);
  end

  // Ends the run when nothing moves for far longer than the reset sweep.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    stall_idle_pct = 0;
    raster_pos = 0;
    cur_threshold = THRESHOLD_RESET;
    cur_width = WIDTH_RESET;
    cur_height = HEIGHT_RESET;
    foreach (prior_pixels[i]) begin
      prior_pixels[i] = '0;
      event_sums[i] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_black_start();
    test_zero_threshold();
    test_threshold_edges();
    test_size_clamp();
    run_random_phase(20, 0, 0);
    run_random_phase(20, 54, 0);
    run_random_phase(20, 0, 54);
    run_random_phase(20, 36, 36);
    test_widest_line();

    settle_block();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> frame_diff_event_accumulator.f
rtl/core/fde_pkg.sv
rtl/core/fde_ram.sv
rtl/core/fde_ctrl.sv
rtl/core/fde_update.sv
rtl/core/frame_diff_event_accumulator.sv
bench/tb.sv
